### hdl/ray_circle_intersect_top_assert.svh
// Assertion macros for the ray/circle intersection block.
`ifndef RAY_CIRCLE_INTERSECT_TOP_ASSERT_SVH
`define RAY_CIRCLE_INTERSECT_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define RCI_ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rci: property check failed");
`define RCI_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("rci: forbidden condition seen");
`else
`define RCI_ASSERT_CLK(name, prop)
`define RCI_ASSERT_NEVER(name, cond)
`endif
`endif

### hdl/rci_pkg.sv
// Shared types, constants and width functions of the ray/circle intersection block.
package rci_pkg;

  localparam int COORD_W = 32;
  localparam int DIR_W   = 18;
  localparam int L_W     = 33;  // centre minus origin
  localparam int PROD_W  = 51;  // L_W x DIR_W signed product
  localparam int TCA_W   = 52;  // sum of two products
  localparam int SQ_W    = 65;  // square of a 33 bit magnitude
  localparam int LSQ_W   = 66;  // |L|^2
  localparam int R2_W    = 32;
  localparam int REACH_W = 31;
  localparam int DIST_W  = 32;
  localparam int LO_W    = 18;  // low split of Tq for the squaring

  localparam logic [DIST_W-1:0] DIST_MAX = 32'h7fff_ffff;
  localparam logic [DIST_W-1:0] DIST_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    OC_HIT_OUT = 3'd0,
    OC_INSIDE  = 3'd1,
    OC_BEHIND  = 3'd2,
    OC_WIDE    = 3'd3,
    OC_RANGE   = 3'd4
  } rci_outcome_e;

  typedef struct packed {
    logic behind;    // Tca below zero
    logic enclosed;  // origin within the circle
    logic wide;      // ThcSq below zero
  } rci_flags_t;

  // Width of Tca rounded down to the fraction point (Tca known non-negative)
  function automatic int tq_w(int frac);
    return TCA_W - 1 - frac;
  endfunction

  // Width of R2 + Tq^2, the largest operand of the ThcSq subtraction
  function automatic int pos_w(int frac);
    int m;
    m = 2 * tq_w(frac);
    if (R2_W + frac > m) m = R2_W + frac;
    if (LSQ_W > m) m = LSQ_W;
    return m + 1;
  endfunction

  function automatic int root_w(int frac);
    return (pos_w(frac) + 1) >> 1;
  endfunction

endpackage

### hdl/rci_if.sv
// Valid/ready channel interfaces for ray items and intersection results.
interface rci_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] origin_x;
  logic signed [31:0] origin_y;
  logic signed [17:0] dir_x;
  logic signed [17:0] dir_y;
  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic        [31:0] radius_squared;
  logic        [30:0] max_reach;

  modport source (
    output valid, origin_x, origin_y, dir_x, dir_y, center_x, center_y,
           radius_squared, max_reach,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, dir_x, dir_y, center_x, center_y,
           radius_squared, max_reach,
    output ready
  );
endinterface

interface rci_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] hit_distance;
  logic        [2:0]  outcome;

  modport source (output valid, hit, hit_distance, outcome, input ready);
  modport sink (input valid, hit, hit_distance, outcome, output ready);
endinterface

### hdl/rci_front.sv
// Front pipeline: L, Tca, |L|^2, Tq^2 and ThcSq with the miss classification flags.
module rci_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      en_i,
  rci_in_if.sink                                    in_i,
  output logic                                      valid_o,
  output logic [rci_pkg::pos_w(FRAC_BITS)-1:0]      thc_o,
  output logic [rci_pkg::tq_w(FRAC_BITS)-1:0]       tq_o,
  output logic [rci_pkg::REACH_W-1:0]               reach_o,
  output rci_pkg::rci_flags_t                       flags_o
);

  localparam int TQ_W   = rci_pkg::tq_w(FRAC_BITS);
  localparam int POS_W  = rci_pkg::pos_w(FRAC_BITS);
  localparam int DIFF_W = POS_W + 1;
  localparam int LO_W   = rci_pkg::LO_W;
  localparam int HI_W   = TQ_W - LO_W;
  localparam int HH_W   = 2 * HI_W;
  localparam int HL_W   = HI_W + LO_W;
  localparam int LL_W   = 2 * LO_W;
  localparam int TQ2_W  = 2 * TQ_W;
  localparam int NSTG   = 7;

  logic [NSTG-1:0] v_q;

  // stage 1
  logic signed [rci_pkg::L_W-1:0]   lx1_q, ly1_q;
  logic signed [rci_pkg::DIR_W-1:0] dx1_q, dy1_q;
  logic [rci_pkg::R2_W-1:0]         r2_1_q, r2_2_q, r2_3_q, r2_4_q, r2_5_q;
  logic [rci_pkg::REACH_W-1:0]      rch1_q, rch2_q, rch3_q, rch4_q, rch5_q, rch6_q, rch7_q;
  // stage 2
  logic [rci_pkg::L_W-1:0]           mlx, mly;
  logic signed [rci_pkg::PROD_W-1:0] px2_q, py2_q;
  logic [rci_pkg::SQ_W-1:0]          sx2_q, sy2_q;
  // stage 3
  logic signed [rci_pkg::TCA_W-1:0]  tca;
  logic                              bh3_q, bh4_q, bh5_q, bh6_q, bh7_q;
  logic [TQ_W-1:0]                   tq3_q, tq4_q, tq5_q, tq6_q, tq7_q;
  logic [rci_pkg::LSQ_W-1:0]         lm3_q, lm4_q, lm5_q, lm6_q;
  // stage 4
  logic [HI_W-1:0]                   tq_hi;
  logic [LO_W-1:0]                   tq_lo;
  logic [HH_W-1:0]                   hh4_q;
  logic [HL_W-1:0]                   hl4_q;
  logic [LL_W-1:0]                   ll4_q;
  logic                              in4_q, in5_q, in6_q, in7_q;
  // stage 5..7
  logic [TQ2_W-1:0]                  tsq5_q;
  logic [POS_W-1:0]                  pos6_q;
  logic [DIFF_W-1:0]                 diff;
  logic [POS_W-1:0]                  thc7_q;
  logic                              wd7_q;

  assign in_i.ready = en_i;

  assign mlx   = lx1_q[rci_pkg::L_W-1] ? (~lx1_q + 1'b1) : lx1_q;
  assign mly   = ly1_q[rci_pkg::L_W-1] ? (~ly1_q + 1'b1) : ly1_q;
  assign tca   = rci_pkg::TCA_W'(px2_q) + rci_pkg::TCA_W'(py2_q);
  assign tq_hi = tq3_q[TQ_W-1:LO_W];
  assign tq_lo = tq3_q[LO_W-1:0];
  assign diff  = DIFF_W'(pos6_q) - DIFF_W'(lm6_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NSTG-2:0], in_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: L = C - O
      lx1_q  <= {in_i.center_x[31], in_i.center_x} - {in_i.origin_x[31], in_i.origin_x};
      ly1_q  <= {in_i.center_y[31], in_i.center_y} - {in_i.origin_y[31], in_i.origin_y};
      dx1_q  <= in_i.dir_x;
      dy1_q  <= in_i.dir_y;
      r2_1_q <= in_i.radius_squared;
      rch1_q <= in_i.max_reach;
      // stage 2: products for Tca and |L|^2
      px2_q  <= rci_pkg::PROD_W'(lx1_q) * rci_pkg::PROD_W'(dx1_q);
      py2_q  <= rci_pkg::PROD_W'(ly1_q) * rci_pkg::PROD_W'(dy1_q);
      sx2_q  <= rci_pkg::SQ_W'(mlx) * rci_pkg::SQ_W'(mlx);
      sy2_q  <= rci_pkg::SQ_W'(mly) * rci_pkg::SQ_W'(mly);
      r2_2_q <= r2_1_q;
      rch2_q <= rch1_q;
      // stage 3: Tca sign, Tq floored to the fraction point, |L|^2
      bh3_q  <= tca[rci_pkg::TCA_W-1];
      tq3_q  <= tca[rci_pkg::TCA_W-2:FRAC_BITS];
      lm3_q  <= rci_pkg::LSQ_W'(sx2_q) + rci_pkg::LSQ_W'(sy2_q);
      r2_3_q <= r2_2_q;
      rch3_q <= rch2_q;
      // stage 4: split squaring of Tq, inside test
      hh4_q  <= HH_W'(tq_hi) * HH_W'(tq_hi);
      hl4_q  <= HL_W'(tq_hi) * HL_W'(tq_lo);
      ll4_q  <= LL_W'(tq_lo) * LL_W'(tq_lo);
      in4_q  <= POS_W'(lm3_q) < (POS_W'(r2_3_q) << FRAC_BITS);
      bh4_q  <= bh3_q;
      tq4_q  <= tq3_q;
      lm4_q  <= lm3_q;
      r2_4_q <= r2_3_q;
      rch4_q <= rch3_q;
      // stage 5: Tq^2, cross term counted twice
      tsq5_q <= {hh4_q, ll4_q} + (TQ2_W'(hl4_q) << (LO_W + 1));
      bh5_q  <= bh4_q;
      in5_q  <= in4_q;
      tq5_q  <= tq4_q;
      lm5_q  <= lm4_q;
      r2_5_q <= r2_4_q;
      rch5_q <= rch4_q;
      // stage 6: R2 + Tq^2
      pos6_q <= POS_W'(tsq5_q) + (POS_W'(r2_5_q) << FRAC_BITS);
      bh6_q  <= bh5_q;
      in6_q  <= in5_q;
      tq6_q  <= tq5_q;
      lm6_q  <= lm5_q;
      rch6_q <= rch5_q;
      // stage 7: ThcSq, clamped at zero; borrow marks a wide pass
      wd7_q  <= diff[POS_W];
      thc7_q <= diff[POS_W] ? '0 : diff[POS_W-1:0];
      bh7_q  <= bh6_q;
      in7_q  <= in6_q;
      tq7_q  <= tq6_q;
      rch7_q <= rch6_q;
    end
  end

  assign valid_o = v_q[NSTG-1];
  assign thc_o   = thc7_q;
  assign tq_o    = tq7_q;
  assign reach_o = rch7_q;
  assign flags_o = '{behind: bh7_q, enclosed: in7_q, wide: wd7_q};

endmodule

### hdl/rci_sqrt_step.sv
// One step of the square-root chain: settles one root bit, forwards the item.
module rci_sqrt_step #(
  parameter int ROOT_W = 36,
  parameter int TQ_W   = 35
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [ROOT_W:0]              rem_i,
  input  logic [ROOT_W-1:0]            root_i,
  input  logic [2*ROOT_W-1:0]          rad_i,
  input  logic [TQ_W-1:0]              tq_i,
  input  logic [rci_pkg::REACH_W-1:0]  reach_i,
  input  rci_pkg::rci_flags_t          flags_i,
  output logic                         valid_o,
  output logic [ROOT_W:0]              rem_o,
  output logic [ROOT_W-1:0]            root_o,
  output logic [2*ROOT_W-1:0]          rad_o,
  output logic [TQ_W-1:0]              tq_o,
  output logic [rci_pkg::REACH_W-1:0]  reach_o,
  output rci_pkg::rci_flags_t          flags_o
);

  localparam int RAD_W  = 2 * ROOT_W;
  localparam int WORK_W = ROOT_W + 3;

  logic                        valid_q;
  logic [WORK_W-1:0]           rem4, trial, sub;
  logic                        ge;
  logic [ROOT_W:0]             rem_d, rem_q;
  logic [ROOT_W-1:0]           root_d, root_q;
  logic [RAD_W-1:0]            rad_q;
  logic [TQ_W-1:0]             tq_q;
  logic [rci_pkg::REACH_W-1:0] reach_q;
  rci_pkg::rci_flags_t         flags_q;

  // bring down the next two radicand bits and try 4*root + 1
  assign rem4   = {rem_i, rad_i[RAD_W-1 -: 2]};
  assign trial  = WORK_W'({root_i, 2'b01});
  assign sub    = rem4 - trial;
  assign ge     = rem4 >= trial;
  assign rem_d  = ge ? sub[ROOT_W:0] : rem4[ROOT_W:0];
  assign root_d = {root_i[ROOT_W-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q   <= rem_d;
      root_q  <= root_d;
      rad_q   <= {rad_i[RAD_W-3:0], 2'b00};
      tq_q    <= tq_i;
      reach_q <= reach_i;
      flags_q <= flags_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign rad_o   = rad_q;
  assign tq_o    = tq_q;
  assign reach_o = reach_q;
  assign flags_o = flags_q;

endmodule

### hdl/ray_circle_intersect_top.sv
// Top level of the 2D ray/circle intersection unit: front pipeline, root chain, output stage.
// Stages: 7 front stages, ROOT_W root steps and 1 output register.
// Throughput: one ray per cycle while no result is held; the root chain settles one bit per step, one step per cycle.
// A held result stalls the whole pipeline, so input ready follows the output register.
// Reset clears only the valid bits; the data path carries no reset.
`include "ray_circle_intersect_top_assert.svh"

module ray_circle_intersect_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rci_in_if.sink    in_i,
  rci_out_if.source out_o
);

  localparam int TQ_W  = rci_pkg::tq_w(FRAC_BITS);
  localparam int POS_W = rci_pkg::pos_w(FRAC_BITS);
  localparam int RW    = rci_pkg::root_w(FRAC_BITS);
  localparam int RAD_W = 2 * RW;
  localparam int T0_W  = ((TQ_W > RW) ? TQ_W : RW) + 1;

  logic                        adv;
  logic                        f_valid;
  logic [POS_W-1:0]            f_thc;
  logic [TQ_W-1:0]             f_tq;
  logic [rci_pkg::REACH_W-1:0] f_reach;
  rci_pkg::rci_flags_t         f_flags;

  logic [RW:0]                 cv;
  logic [RW:0]                 rem_c   [RW+1];
  logic [RW-1:0]               root_c  [RW+1];
  logic [RAD_W-1:0]            rad_c   [RW+1];
  logic [TQ_W-1:0]             tq_c    [RW+1];
  logic [rci_pkg::REACH_W-1:0] reach_c [RW+1];
  rci_pkg::rci_flags_t         flags_c [RW+1];

  logic signed [T0_W-1:0]      t0;
  logic                        neg, beyond;
  logic [rci_pkg::DIST_W-1:0]  t0_sat;

  logic                        out_v_q;
  logic                        hit_d, hit_q;
  logic [rci_pkg::DIST_W-1:0]  dist_d, dist_q;
  rci_pkg::rci_outcome_e       oc_d, oc_q;

  // pipeline moves unless a finished result is still waiting
  assign adv = !out_v_q || out_o.ready;

  rci_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .in_i    (in_i),
    .valid_o (f_valid),
    .thc_o   (f_thc),
    .tq_o    (f_tq),
    .reach_o (f_reach),
    .flags_o (f_flags)
  );

  assign cv[0]      = f_valid;
  assign rem_c[0]   = '0;
  assign root_c[0]  = '0;
  assign rad_c[0]   = RAD_W'(f_thc);
  assign tq_c[0]    = f_tq;
  assign reach_c[0] = f_reach;
  assign flags_c[0] = f_flags;

  for (genvar k = 0; k < RW; k++) begin : g_chain
    rci_sqrt_step #(.ROOT_W(RW), .TQ_W(TQ_W)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (cv[k]),
      .rem_i   (rem_c[k]),
      .root_i  (root_c[k]),
      .rad_i   (rad_c[k]),
      .tq_i    (tq_c[k]),
      .reach_i (reach_c[k]),
      .flags_i (flags_c[k]),
      .valid_o (cv[k+1]),
      .rem_o   (rem_c[k+1]),
      .root_o  (root_c[k+1]),
      .rad_o   (rad_c[k+1]),
      .tq_o    (tq_c[k+1]),
      .reach_o (reach_c[k+1]),
      .flags_o (flags_c[k+1])
    );
  end

  // T0 = Tq - sqrt(ThcSq), then range checks and saturation
  assign t0     = T0_W'(tq_c[RW]) - T0_W'(root_c[RW]);
  assign neg    = t0[T0_W-1];
  assign beyond = !neg && (t0[T0_W-2:0] > (T0_W-1)'(reach_c[RW]));

  always_comb begin
    if (!neg && (|t0[T0_W-2:rci_pkg::DIST_W-1])) begin
      t0_sat = rci_pkg::DIST_MAX;
    end else if (neg && !(&t0[T0_W-2:rci_pkg::DIST_W-1])) begin
      t0_sat = rci_pkg::DIST_MIN;
    end else begin
      t0_sat = t0[rci_pkg::DIST_W-1:0];
    end
  end

  always_comb begin
    hit_d  = 1'b0;
    dist_d = '0;
    oc_d   = rci_pkg::OC_HIT_OUT;
    if (flags_c[RW].behind) begin
      oc_d = rci_pkg::OC_BEHIND;
    end else if (flags_c[RW].enclosed) begin
      oc_d   = rci_pkg::OC_INSIDE;
      hit_d  = 1'b1;
      dist_d = t0_sat;
    end else if (flags_c[RW].wide) begin
      oc_d = rci_pkg::OC_WIDE;
    end else if (neg || beyond) begin
      oc_d = rci_pkg::OC_RANGE;
    end else begin
      hit_d  = 1'b1;
      dist_d = t0_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= cv[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q  <= hit_d;
      dist_q <= dist_d;
      oc_q   <= oc_d;
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.hit          = hit_q;
  assign out_o.hit_distance = dist_q;
  assign out_o.outcome      = oc_q;

  `RCI_ASSERT_CLK(a_hit_matches_code, out_v_q |-> (hit_q == (oc_q == rci_pkg::OC_HIT_OUT || oc_q == rci_pkg::OC_INSIDE)))
  `RCI_ASSERT_NEVER(a_miss_has_zero_dist, out_v_q && !hit_q && (dist_q != '0))
  `RCI_ASSERT_NEVER(a_outside_hit_nonneg, out_v_q && (oc_q == rci_pkg::OC_HIT_OUT) && dist_q[rci_pkg::DIST_W-1])
  `RCI_ASSERT_CLK(a_chain_holds_on_stall, (cv[RW] && !adv) |=> cv[RW])

endmodule

### bench/rci_crossing_check.sv
// Watches both channels of the ray/circle block, predicts each crossing and compares results.
module rci_crossing_check #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  rci_in_if    ray_mon,
  rci_out_if   res_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o,
  output int   outcome_tally_o [5]
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint DIST_HI = 64'sd2147483647;
  localparam longint DIST_LO = -64'sd2147483648;

  typedef struct packed {
    logic                  hit;
    logic signed [31:0]    distance;
    rci_pkg::rci_outcome_e outcome;
  } crossing_t;

  crossing_t crossings_due [$];
  int fails = 0;
  int checked = 0;
  int tally [5] = '{default: 0};

  // floor of the square root of a Q.2F value, giving Q.F
  function automatic logic [63:0] floor_root(input logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= n) r = c;
    end
    return r;
  endfunction

  function automatic crossing_t trace_ray(
    input logic signed [31:0] ox, oy,
    input logic signed [17:0] dx, dy,
    input logic signed [31:0] cx, cy,
    input logic        [31:0] r2,
    input logic        [30:0] reach
  );
    longint       lx, ly, tca, tq, t0;
    logic [63:0]  lx_mag, ly_mag;
    logic [127:0] lsq, r2w, pos, thc;
    crossing_t    c;
    lx  = longint'(cx) - longint'(ox);
    ly  = longint'(cy) - longint'(oy);
    tca = lx * longint'(dx) + ly * longint'(dy);
    c.hit     = 1'b0;
    c.outcome = rci_pkg::OC_BEHIND;
    t0        = 0;
    if (tca >= 0) begin
      tq     = tca >>> FRAC_BITS;
      lx_mag = (lx < 0) ? -lx : lx;
      ly_mag = (ly < 0) ? -ly : ly;
      lsq    = {64'd0, lx_mag} * {64'd0, lx_mag} + {64'd0, ly_mag} * {64'd0, ly_mag};
      r2w    = {96'd0, r2} << FRAC_BITS;
      pos    = r2w + {64'd0, 64'(tq)} * {64'd0, 64'(tq)};
      if (lsq < r2w) begin
        // origin inside: the distance is reported even when negative
        thc       = (pos < lsq) ? '0 : pos - lsq;
        t0        = tq - longint'(floor_root(thc));
        c.outcome = rci_pkg::OC_INSIDE;
        c.hit     = 1'b1;
      end else if (pos < lsq) begin
        c.outcome = rci_pkg::OC_WIDE;
      end else begin
        t0 = tq - longint'(floor_root(pos - lsq));
        if (t0 < 0 || t0 > longint'(reach)) begin
          c.outcome = rci_pkg::OC_RANGE;
          t0        = 0;
        end else begin
          c.outcome = rci_pkg::OC_HIT_OUT;
          c.hit     = 1'b1;
        end
      end
    end
    if (t0 > DIST_HI) c.distance = rci_pkg::DIST_MAX;
    else if (t0 < DIST_LO) c.distance = rci_pkg::DIST_MIN;
    else c.distance = t0[31:0];
    return c;
  endfunction

  // results are compared before new rays are queued, so a result can never
  // match a ray offered in the same cycle
  always @(posedge clk_i or negedge rst_ni) begin : compare_results
    crossing_t due;
    if (!rst_ni) begin
      crossings_due.delete();
      fail_count_o    <= 0;
      pending_o       <= 0;
      checked_o       <= 0;
      outcome_tally_o <= '{default: 0};
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (crossings_due.size() == 0) begin
          $error("result transfer with no ray outstanding: hit=%0b distance=%0d outcome=%0d",
                 res_mon.hit, res_mon.hit_distance, res_mon.outcome);
          fails++;
        end else begin
          due = crossings_due.pop_front();
          if (res_mon.hit !== due.hit) begin
            $error("hit: expected %0b, actual %0b", due.hit, res_mon.hit);
            fails++;
          end
          if (res_mon.hit_distance !== due.distance) begin
            $error("hit_distance: expected %0d, actual %0d", due.distance,
                   res_mon.hit_distance);
            fails++;
          end
          if (res_mon.outcome !== due.outcome) begin
            $error("outcome: expected %0d, actual %0d", due.outcome, res_mon.outcome);
            fails++;
          end
          checked++;
          tally[due.outcome]++;
        end
      end
      if (ray_mon.valid && ray_mon.ready) begin
        crossings_due.push_back(trace_ray(ray_mon.origin_x, ray_mon.origin_y,
                                          ray_mon.dir_x, ray_mon.dir_y,
                                          ray_mon.center_x, ray_mon.center_y,
                                          ray_mon.radius_squared, ray_mon.max_reach));
      end
      fail_count_o    <= fails;
      pending_o       <= crossings_due.size();
      checked_o       <= checked;
      outcome_tally_o <= tally;
    end
  end

endmodule

### bench/tb.sv
// Testbench top: offers rays to the intersection block, paces its results and gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                 ONE       = 1 << 16;
  localparam int                 N_CORNER  = 21;
  localparam int                 N_RANDOM  = 550;
  localparam logic signed [31:0] COORD_LO  = 32'sh8000_0000;
  localparam logic signed [31:0] COORD_HI  = 32'sh7fff_ffff;
  localparam logic signed [17:0] DIR_ONE   = 18'sh1_0000;
  localparam logic signed [17:0] DIR_MIN   = 18'sh2_0000;
  localparam logic signed [17:0] DIR_MAX   = 18'sh1_ffff;
  localparam logic        [31:0] R2_MAX    = 32'hffff_ffff;
  localparam logic        [30:0] REACH_MAX = 31'h7fff_ffff;
  localparam logic        [30:0] REACH_8   = 31'h0008_0000;

  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [17:0] dx;
    logic signed [17:0] dy;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic        [31:0] r2;
    logic        [30:0] reach;
  } ray_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   checked;
  int   tally [5];
  int   rays_sent = 0;

  rci_in_if  ray_ch ();
  rci_out_if res_ch ();

  ray_circle_intersect_top #(.FRAC_BITS(16)) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (ray_ch),
    .out_o  (res_ch)
  );

  rci_crossing_check #(.FRAC_BITS(16)) crossing_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .ray_mon         (ray_ch),
    .res_mon         (res_ch),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .outcome_tally_o (tally)
  );

  // ox, oy, dx, dy, cx, cy, r2, reach
  ray_t corner_rays [N_CORNER] = '{
    '{0, 0, DIR_ONE, 0, 10*ONE, 0, 4*ONE, REACH_MAX},       // plain hit at 8
    '{0, 0, DIR_ONE, 0, 10*ONE, 0, 4*ONE, REACH_8},         // hit exactly at reach
    '{0, 0, DIR_ONE, 0, 10*ONE, 0, 4*ONE, REACH_8 - 31'd1}, // just beyond reach
    '{3*ONE, -5*ONE, DIR_ONE, 0, 3*ONE, -5*ONE, 4*ONE, REACH_MAX}, // origin at centre
    '{0, 0, DIR_ONE, 0, -10*ONE, 0, 4*ONE, REACH_MAX},      // pointing away
    '{0, 0, DIR_ONE, 0, -ONE/2, 0, 4*ONE, REACH_MAX},       // pointing away from inside
    '{0, 0, DIR_ONE, 0, 10*ONE, 10*ONE, ONE, REACH_MAX},    // passes wide
    '{0, 0, DIR_ONE, 0, 10*ONE, 2*ONE, 4*ONE, REACH_MAX},   // tangent
    '{0, 0, DIR_ONE, 0, 2*ONE, 0, 4*ONE, 0},                // origin on the rim, zero reach
    '{0, 0, 0, DIR_ONE, 0, 7*ONE, 0, REACH_MAX},            // zero radius on the ray
    '{0, 0, 0, 0, 5*ONE, 0, ONE, REACH_MAX},                // zero direction, outside
    '{0, 0, 0, 0, 0, 0, 9*ONE, REACH_MAX},                  // zero direction, inside
    '{0, 0, DIR_MAX, 0, 10*ONE, 0, 4*ONE, REACH_MAX},       // overlong direction
    '{0, 0, DIR_MIN, DIR_MIN, -10*ONE, -10*ONE, ONE, REACH_MAX},
    '{COORD_LO, COORD_LO, DIR_MAX, DIR_MAX, COORD_HI, COORD_HI, R2_MAX, REACH_MAX},
    '{COORD_HI, COORD_HI, DIR_MIN, DIR_MIN, COORD_LO, COORD_LO, R2_MAX, 0},
    '{0, 0, DIR_ONE, 0, ONE, 0, R2_MAX, REACH_MAX},         // huge circle around origin
    '{-4*ONE, -4*ONE, 46341, 46341, 4*ONE, 4*ONE, ONE, REACH_MAX},
    '{0, 0, 0, 0, 0, 0, 0, 0},
    '{5*ONE, 0, -DIR_ONE, 0, -5*ONE, 0, ONE, REACH_MAX},
    '{1, 2, DIR_ONE, 3, 100, 7, 5, 3}                       // sub-unit values
  };

  function automatic ray_t draw_ray();
    ray_t   r;
    int     kind;
    longint dxl, dyl, px, py, along, side, rad;
    kind    = $urandom_range(0, 99);
    r.ox    = $urandom;
    r.oy    = $urandom;
    r.dx    = 18'($urandom);
    r.dy    = 18'($urandom);
    r.cx    = $urandom;
    r.cy    = $urandom;
    r.r2    = $urandom;
    r.reach = 31'($urandom);
    if (kind < 15) return r;
    // unit direction: pick x, derive y by integer root
    dxl = longint'($urandom_range(0, 2 * ONE)) - ONE;
    dyl = 0;
    for (int b = 16; b >= 0; b--)
      if ((dyl | (64'sd1 << b)) * (dyl | (64'sd1 << b)) <= (64'sd1 << 32) - dxl * dxl)
        dyl = dyl | (64'sd1 << b);
    if ($urandom_range(0, 1)) dyl = -dyl;
    rad  = longint'($urandom_range(0, 1 << $urandom_range(6, 23)));
    r.r2 = 32'((rad * rad) >>> 16);
    if (kind >= 80 && kind < 90) begin
      along = ((longint'($urandom_range(0, 200)) - 100) * rad) / 200;
      side  = ((longint'($urandom_range(0, 200)) - 100) * rad) / 200;
    end else begin
      along = longint'($urandom_range(0, 1 << $urandom_range(12, 26)));
      if ($urandom_range(0, 3) == 0) along = -along;
      side = ((longint'($urandom_range(0, 300)) - 150) * rad) / 100;
    end
    px   = longint'($urandom_range(0, 1 << 29)) - (64'sd1 << 28);
    py   = longint'($urandom_range(0, 1 << 29)) - (64'sd1 << 28);
    r.ox = 32'(px);
    r.oy = 32'(py);
    r.cx = 32'(px + ((along * dxl - side * dyl) >>> 16));
    r.cy = 32'(py + ((along * dyl + side * dxl) >>> 16));
    r.dx = 18'(dxl);
    r.dy = 18'(dyl);
    case ($urandom_range(0, 2))
      0:       r.reach = REACH_MAX;
      1:       r.reach = 31'($urandom_range(0, 32'(2 * ((along < 0) ? -along : along) + 1)));
      default: ;
    endcase
    if (kind >= 90) begin
      r.dx = 18'($urandom);
      r.dy = 18'($urandom);
    end
    return r;
  endfunction

  task automatic offer_ray(input ray_t r, input bit eager);
    int gap;
    gap = eager ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      ray_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ray_ch.valid          <= 1'b1;
    ray_ch.origin_x       <= r.ox;
    ray_ch.origin_y       <= r.oy;
    ray_ch.dir_x          <= r.dx;
    ray_ch.dir_y          <= r.dy;
    ray_ch.center_x       <= r.cx;
    ray_ch.center_y       <= r.cy;
    ray_ch.radius_squared <= r.r2;
    ray_ch.max_reach      <= r.reach;
    do @(posedge clk); while (!ray_ch.ready);
    rays_sent++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin : stimulus
    ray_ch.valid          <= 1'b0;
    ray_ch.origin_x       <= '0;
    ray_ch.origin_y       <= '0;
    ray_ch.dir_x          <= '0;
    ray_ch.dir_y          <= '0;
    ray_ch.center_x       <= '0;
    ray_ch.center_y       <= '0;
    ray_ch.radius_squared <= '0;
    ray_ch.max_reach      <= '0;
    wait (rst_n);
    @(posedge clk);
    for (int n = 0; n < N_CORNER; n++) offer_ray(corner_rays[n], n >= 14);
    // every third block of fifty goes back to back
    for (int n = 0; n < N_RANDOM; n++) offer_ray(draw_ray(), ((n / 50) % 3) == 2);
    ray_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // room for any stray result still in the pipeline
    repeat (60) @(posedge clk);
    $display("tb: %0d rays offered, %0d results checked", rays_sent, checked);
    $display("tb: hit outside %0d, inside %0d, behind %0d, wide %0d, out of reach %0d",
             tally[0], tally[1], tally[2], tally[3], tally[4]);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : drain
    int hold;
    int taken;
    taken = 0;
    res_ch.ready <= 1'b0;
    wait (rst_n);
    forever begin
      // long hold-offs fill the pipeline and stall the input side
      if (taken == 150 || taken == 420) hold = 300;
      else if (((taken / 40) % 3) == 1) hold = 0;
      else hold = $urandom_range(0, 3);
      if (hold > 0) begin
        res_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
      taken++;
    end
  end

  initial begin : watchdog
    #500us;
    $display("tb: failure");
    $finish;
  end

endmodule
